/* sv/mm3_pkg.sv */
// shared types, constants and helpers for the streaming murmur3 x64 hash
// used by mm3_ctrl, mm3_datapath and murmur3_64bit_stream_hash
// no dependencies
package mm3_pkg;

    // mixing and finalisation constants
    localparam logic [63:0] MIX_C1    = 64'h87c3_7b91_1142_53d5;
    localparam logic [63:0] MIX_C2    = 64'h4cf5_ad43_2745_937f;
    localparam logic [63:0] LANE1_ADD = 64'h0000_0000_52dc_e729;
    localparam logic [63:0] LANE2_ADD = 64'h0000_0000_3849_5ab5;
    localparam logic [63:0] FMIX_M1   = 64'hff51_afd7_ed55_8ccd;
    localparam logic [63:0] FMIX_M2   = 64'hc4ce_b9fe_1a85_ec53;
    localparam logic [31:0] SEED_RESET = 32'hBEEF_CAFE;

    // bytes in one full block
    localparam logic [63:0] BLOCK_BYTES = 64'd16;
    // bytes in the low word; a count above this leaves valid bytes in the high word
    localparam logic [4:0] LOW_WORD_BYTES = 5'd8;

    // 64x64 low product built from three 32x32 partial products
    localparam logic [1:0] MUL_LAST = 2'd2;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_SEED,
        OP_LOAD,
        OP_KM,
        OP_KROT,
        OP_HA,
        OP_HB,
        OP_HX,
        OP_KHI,
        OP_FINA,
        OP_FINB,
        OP_FLD,
        OP_FXS,
        OP_FST,
        OP_OUT
    } dp_op_t;

    typedef enum logic [1:0] {
        MC_C1,
        MC_C2,
        MC_M1,
        MC_M2
    } mul_const_t;

    typedef struct packed {
        dp_op_t     op;
        logic       lane;
        logic [1:0] mul_step;
        mul_const_t mul_const;
    } dp_cmd_t;

    typedef struct packed {
        logic body;
        logic is_final;
        logic has_low;
        logic has_high;
        logic out_free;
    } dp_sts_t;

    function automatic logic [63:0] mul_const_value(input mul_const_t sel);
        logic [63:0] v;
        case (sel)
            MC_C1:   v = MIX_C1;
            MC_C2:   v = MIX_C2;
            MC_M1:   v = FMIX_M1;
            MC_M2:   v = FMIX_M2;
            default: v = MIX_C1;
        endcase
        return v;
    endfunction

endpackage

/* sv/mm3_datapath.sv */
// datapath of the streaming murmur3 hash: lane, length, work and output registers
// and one shared 32x32 multiplier, driven by commands from mm3_ctrl
// depends on mm3_pkg
module mm3_datapath
    import mm3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_sts_t     sts,
    input  logic [31:0] hash_seed,
    input  logic [63:0] block_low_word,
    input  logic [63:0] block_high_word,
    input  logic [4:0]  valid_bytes,
    input  logic        final_block,
    output logic        hash_valid,
    input  logic        hash_stall,
    output logic [63:0] hash_value
);

    logic [31:0]  seed_reg, seed_next;
    logic [63:0]  h1_reg, h1_next;
    logic [63:0]  h2_reg, h2_next;
    logic [63:0]  total_reg, total_next;
    logic         hash_valid_reg, hash_valid_next;

    logic [63:0]  k_reg, k_next;
    logic [63:0]  acc_reg, acc_next;
    logic [63:0]  hi_reg, hi_next;
    logic [4:0]   count_reg, count_next;
    logic         final_reg, final_next;
    logic         body_reg, body_next;
    logic [63:0]  hash_value_reg, hash_value_next;

    logic         in_body;
    logic [127:0] keep;
    logic [63:0]  mconst;
    logic [31:0]  mul_a, mul_b;
    logic [63:0]  prod;
    logic [63:0]  prod_shl;
    logic [63:0]  h1_x, h2_x;
    logic [63:0]  k_fold;
    logic         out_free;

    assign in_body = !final_block || valid_bytes[4];

    // byte keep mask for the incoming item
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            keep[8*i +: 8] = (in_body || (5'(i) < valid_bytes)) ? 8'hff : 8'h00;
        end
    end

    // one 32x32 multiplier, three passes give the low 64 bits of k * const
    assign mconst   = mul_const_value(cmd.mul_const);
    assign mul_a    = (cmd.mul_step == MUL_LAST) ? k_reg[63:32] : k_reg[31:0];
    assign mul_b    = (cmd.mul_step == 2'd1) ? mconst[63:32] : mconst[31:0];
    assign prod     = 64'(mul_a) * 64'(mul_b);
    assign prod_shl = {prod[31:0], 32'h0};

    assign h1_x     = h1_reg ^ total_reg;
    assign h2_x     = h2_reg ^ total_reg;
    assign k_fold   = k_reg ^ {33'h0, k_reg[63:33]};
    assign out_free = !hash_valid_reg || !hash_stall;

    always_comb
    begin
        seed_next       = seed_reg;
        h1_next         = h1_reg;
        h2_next         = h2_reg;
        total_next      = total_reg;
        k_next          = k_reg;
        acc_next        = acc_reg;
        hi_next         = hi_reg;
        count_next      = count_reg;
        final_next      = final_reg;
        body_next       = body_reg;
        hash_value_next = hash_value_reg;
        hash_valid_next = hash_valid_reg && hash_stall;

        case (cmd.op)
            OP_NOP:
            begin
            end
            OP_SEED:
            begin
                seed_next  = hash_seed;
                h1_next    = {32'h0, hash_seed};
                h2_next    = {32'h0, hash_seed};
                total_next = '0;
            end
            OP_LOAD:
            begin
                k_next     = block_low_word & keep[63:0];
                hi_next    = block_high_word & keep[127:64];
                count_next = valid_bytes;
                final_next = final_block;
                body_next  = in_body;
                total_next = total_reg + (in_body ? BLOCK_BYTES : 64'(valid_bytes));
            end
            OP_KM:
            begin
                case (cmd.mul_step)
                    2'd0:     acc_next = prod;
                    2'd1:     acc_next = acc_reg + prod_shl;
                    default:  k_next   = acc_reg + prod_shl;
                endcase
            end
            OP_KROT:
            begin
                // rotl 31 for lane one, rotl 33 for lane two
                k_next = cmd.lane ? {k_reg[30:0], k_reg[63:31]}
                                  : {k_reg[32:0], k_reg[63:33]};
            end
            OP_HA:
            begin
                if (cmd.lane)
                begin
                    h2_next = {h2_reg[32:0] ^ k_reg[32:0], h2_reg[63:33] ^ k_reg[63:33]}
                              + h1_reg;
                end
                else
                begin
                    h1_next = {h1_reg[36:0] ^ k_reg[36:0], h1_reg[63:37] ^ k_reg[63:37]}
                              + h2_reg;
                end
            end
            OP_HB:
            begin
                if (cmd.lane)
                begin
                    h2_next = {h2_reg[61:0], 2'b00} + h2_reg + LANE2_ADD;
                end
                else
                begin
                    h1_next = {h1_reg[61:0], 2'b00} + h1_reg + LANE1_ADD;
                end
            end
            OP_HX:
            begin
                if (cmd.lane)
                begin
                    h2_next = h2_reg ^ k_reg;
                end
                else
                begin
                    h1_next = h1_reg ^ k_reg;
                end
            end
            OP_KHI:
            begin
                k_next = hi_reg;
            end
            OP_FINA:
            begin
                h1_next = h1_x + h2_x;
                h2_next = h2_x;
            end
            OP_FINB:
            begin
                h2_next = h2_reg + h1_reg;
            end
            OP_FLD:
            begin
                k_next = cmd.lane ? h2_reg : h1_reg;
            end
            OP_FXS:
            begin
                k_next = k_fold;
            end
            OP_FST:
            begin
                if (cmd.lane)
                begin
                    h2_next = k_fold;
                end
                else
                begin
                    h1_next = k_fold;
                end
            end
            OP_OUT:
            begin
                hash_value_next = h1_reg + h2_reg;
                hash_valid_next = 1'b1;
                h1_next         = {32'h0, seed_reg};
                h2_next         = {32'h0, seed_reg};
                total_next      = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg       <= SEED_RESET;
            h1_reg         <= {32'h0, SEED_RESET};
            h2_reg         <= {32'h0, SEED_RESET};
            total_reg      <= '0;
            hash_valid_reg <= 1'b0;
        end
        else
        begin
            seed_reg       <= seed_next;
            h1_reg         <= h1_next;
            h2_reg         <= h2_next;
            total_reg      <= total_next;
            hash_valid_reg <= hash_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        acc_reg        <= acc_next;
        hi_reg         <= hi_next;
        count_reg      <= count_next;
        final_reg      <= final_next;
        body_reg       <= body_next;
        hash_value_reg <= hash_value_next;
    end

    assign sts.body     = body_reg;
    assign sts.is_final = final_reg;
    assign sts.has_low  = (count_reg != 5'd0);
    assign sts.has_high = (count_reg > LOW_WORD_BYTES);
    assign sts.out_free = out_free;

    assign hash_valid = hash_valid_reg;
    assign hash_value = hash_value_reg;

    // a result is only written into a free output register
    a_out_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_OUT) |-> out_free)
        else $error("result written over an untaken result");

    // a written result is offered on the next cycle
    a_out_offered: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_OUT) |=> hash_valid_reg)
        else $error("result not offered after write");

    // message restart leaves the length at zero
    a_restart_len: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_OUT || cmd.op == OP_SEED) |=> (total_reg == 64'h0))
        else $error("length not cleared on restart");

endmodule

/* sv/mm3_ctrl.sv */
// controller of the streaming murmur3 hash: one-hot sequencer that walks the
// body mix, tail mix and finalisation and issues datapath commands
// depends on mm3_pkg
module mm3_ctrl
    import mm3_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    seed_valid,
    output logic    seed_ready,
    input  logic    block_valid,
    output logic    block_stall,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [17:0] {
        S_IDLE     = 18'h00001,
        S_DISPATCH = 18'h00002,
        S_KM1      = 18'h00004,
        S_KROT     = 18'h00008,
        S_KM2      = 18'h00010,
        S_HA       = 18'h00020,
        S_HB       = 18'h00040,
        S_HX       = 18'h00080,
        S_KHI      = 18'h00100,
        S_FINA     = 18'h00200,
        S_FINB     = 18'h00400,
        S_FLD      = 18'h00800,
        S_FX1      = 18'h01000,
        S_FM1      = 18'h02000,
        S_FX2      = 18'h04000,
        S_FM2      = 18'h08000,
        S_FST      = 18'h10000,
        S_OUT      = 18'h20000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        lane_reg, lane_next;
    logic [1:0]  mul_step_reg, mul_step_next;
    logic        idle;
    logic        mul_done;

    assign idle        = (state_reg == S_IDLE);
    assign seed_ready  = idle;
    assign block_stall = !idle || seed_valid;
    assign mul_done    = (mul_step_reg == MUL_LAST);

    always_comb
    begin
        state_next    = state_reg;
        lane_next     = lane_reg;
        mul_step_next = mul_step_reg;
        cmd.op        = OP_NOP;
        cmd.lane      = lane_reg;
        cmd.mul_step  = mul_step_reg;
        cmd.mul_const = MC_C1;

        case (state_reg)
            S_IDLE:
            begin
                if (seed_valid)
                begin
                    cmd.op = OP_SEED;
                end
                else if (block_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                lane_next  = 1'b0;
                state_next = (sts.body || sts.has_low) ? S_KM1 : S_FINA;
            end
            S_KM1:
            begin
                cmd.op        = OP_KM;
                cmd.mul_const = lane_reg ? MC_C2 : MC_C1;
                mul_step_next = mul_done ? 2'd0 : mul_step_reg + 2'd1;
                if (mul_done)
                begin
                    state_next = S_KROT;
                end
            end
            S_KROT:
            begin
                cmd.op     = OP_KROT;
                state_next = S_KM2;
            end
            S_KM2:
            begin
                cmd.op        = OP_KM;
                cmd.mul_const = lane_reg ? MC_C1 : MC_C2;
                mul_step_next = mul_done ? 2'd0 : mul_step_reg + 2'd1;
                if (mul_done)
                begin
                    state_next = sts.body ? S_HA : S_HX;
                end
            end
            S_HA:
            begin
                cmd.op     = OP_HA;
                state_next = S_HB;
            end
            S_HB:
            begin
                cmd.op = OP_HB;
                if (!lane_reg)
                begin
                    state_next = S_KHI;
                end
                else
                begin
                    state_next = sts.is_final ? S_FINA : S_IDLE;
                end
            end
            S_HX:
            begin
                cmd.op     = OP_HX;
                state_next = (!lane_reg && sts.has_high) ? S_KHI : S_FINA;
            end
            S_KHI:
            begin
                cmd.op     = OP_KHI;
                lane_next  = 1'b1;
                state_next = S_KM1;
            end
            S_FINA:
            begin
                cmd.op     = OP_FINA;
                state_next = S_FINB;
            end
            S_FINB:
            begin
                cmd.op     = OP_FINB;
                lane_next  = 1'b0;
                state_next = S_FLD;
            end
            S_FLD:
            begin
                cmd.op     = OP_FLD;
                state_next = S_FX1;
            end
            S_FX1:
            begin
                cmd.op     = OP_FXS;
                state_next = S_FM1;
            end
            S_FM1:
            begin
                cmd.op        = OP_KM;
                cmd.mul_const = MC_M1;
                mul_step_next = mul_done ? 2'd0 : mul_step_reg + 2'd1;
                if (mul_done)
                begin
                    state_next = S_FX2;
                end
            end
            S_FX2:
            begin
                cmd.op     = OP_FXS;
                state_next = S_FM2;
            end
            S_FM2:
            begin
                cmd.op        = OP_KM;
                cmd.mul_const = MC_M2;
                mul_step_next = mul_done ? 2'd0 : mul_step_reg + 2'd1;
                if (mul_done)
                begin
                    state_next = S_FST;
                end
            end
            S_FST:
            begin
                cmd.op = OP_FST;
                if (!lane_reg)
                begin
                    lane_next  = 1'b1;
                    state_next = S_FLD;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            lane_reg     <= 1'b0;
            mul_step_reg <= 2'd0;
        end
        else
        begin
            state_reg    <= state_next;
            lane_reg     <= lane_next;
            mul_step_reg <= mul_step_next;
        end
    end

    // an accepted block is always dispatched next
    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (block_valid && !block_stall) |=> (state_reg == S_DISPATCH))
        else $error("accepted block not dispatched");

    // partial product counter is parked whenever no multiply runs
    a_step_parked: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op != OP_KM) |-> (mul_step_reg == 2'd0))
        else $error("multiply step counter left running");

    // seed write and block transfer never coincide
    a_cfg_vs_block: assert property (@(posedge clk) disable iff (!rst_n)
        (seed_valid && seed_ready) |-> block_stall)
        else $error("seed write alongside block transfer");

endmodule

/* sv/murmur3_64bit_stream_hash.sv */
// top level of the streaming murmur3 x64 hash (low 64-bit half)
// instantiates mm3_ctrl and mm3_datapath, depends on mm3_pkg
//
// Takes a message as 16-byte blocks (two little-endian 64-bit words per
// transfer) and returns the low 64 bits of the x64_128 hash after each
// block marked final_block. A final block may carry 0 to 16 valid bytes;
// bytes past valid_bytes are ignored, a count above 16 counts as 16, and a
// block that is not final is always taken as a full 16 bytes. One 32x32
// multiplier is shared by every 64-bit product, and the input is stalled
// from the transfer of a block until it is mixed in, and for a final block
// until the final step (length fold, cross-adds and two fmix passes) has
// written the hash; a short tail takes fewer steps than a full block.
// The result sits in an output register, so the next message can be
// started while the hash is still waiting to be taken; the block only
// waits at the end of a message if the previous hash has not been taken
// yet. hash_seed is written over the seed port while idle; a write
// restarts the message with the new seed.
// Reset seed is 0xBEEFCAFE.
module murmur3_64bit_stream_hash
    import mm3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // seed register write
    input  logic        seed_valid,
    output logic        seed_ready,
    input  logic [31:0] hash_seed,
    // block input
    input  logic        block_valid,
    output logic        block_stall,
    input  logic [63:0] block_low_word,
    input  logic [63:0] block_high_word,
    input  logic [4:0]  valid_bytes,
    input  logic        final_block,
    // hash output
    output logic        hash_valid,
    input  logic        hash_stall,
    output logic [63:0] hash_value
);

    // command and status between sequencer and datapath
    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencer: owns the handshakes on the input and seed side
    mm3_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .seed_valid  (seed_valid),
        .seed_ready  (seed_ready),
        .block_valid (block_valid),
        .block_stall (block_stall),
        .sts         (sts),
        .cmd         (cmd)
    );

    // datapath: lanes, length, shared multiplier and the output register
    mm3_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .hash_seed       (hash_seed),
        .block_low_word  (block_low_word),
        .block_high_word (block_high_word),
        .valid_bytes     (valid_bytes),
        .final_block     (final_block),
        .hash_valid      (hash_valid),
        .hash_stall      (hash_stall),
        .hash_value      (hash_value)
    );

endmodule
